// ----- hw/rtl/ip_prefix_compare_top_assert.svh -----
// ----------------------------------------------------------------------------
// ip_prefix_compare_top_assert.svh
// Assertion macros used by the checker of the prefix compare block.
// ----------------------------------------------------------------------------
`ifndef IP_PREFIX_COMPARE_TOP_ASSERT_SVH
`define IP_PREFIX_COMPARE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define IPC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prefix compare: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define IPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prefix compare: next-cycle check failed");

`endif

// ----- hw/rtl/ipc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Types, codes and field layout of the IP prefix compare block.
// ----------------------------------------------------------------------------
package ipc_pkg;

	localparam int unsigned ADDR_W      = 128;
	localparam int unsigned HALF_W      = 64;
	localparam int unsigned MASK_W      = 32;
	localparam int unsigned LEN_W       = 8;
	localparam int unsigned FULL_PREFIX = 128;
	localparam int unsigned V4_W        = 32;
	localparam int unsigned IN_DATA_W   = 328;
	localparam int unsigned OUT_DATA_W  = 8;

	// Operation codes
	typedef enum logic [2:0] {
		OP_EQ       = 3'd0,
		OP_NE       = 3'd1,
		OP_SUBSET   = 3'd2,
		OP_GT       = 3'd3,
		OP_GE       = 3'd4,
		OP_SUPERSET = 3'd5,
		OP_LT       = 3'd6,
		OP_LE       = 3'd7
	} op_t;

	// Verdict codes
	typedef enum logic [1:0] {
		V_TRUE  = 2'd0,
		V_FALSE = 2'd1,
		V_ERROR = 2'd2
	} verdict_t;

endpackage

// ----- hw/rtl/ipc_prefix_mask.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_prefix_mask
// Expands an IPv4 netmask or an IPv6 prefix length into a 128-bit mask.
// ----------------------------------------------------------------------------
module ipc_prefix_mask (
	input  logic                          v6,
	input  logic [ipc_pkg::MASK_W-1:0]    mask_val,  // netmask, or clamped prefix length
	output logic [ipc_pkg::ADDR_W-1:0]    mask_vec
);

	logic [ipc_pkg::LEN_W-1:0] len;

	assign len = mask_val[ipc_pkg::LEN_W-1:0];

	// Build a thermometer from the top bit down for IPv6, pass the netmask for IPv4
	always_comb begin
		mask_vec = '0;
		if (v6) begin
			for (int i = 0; i < ipc_pkg::ADDR_W; i++) begin
				mask_vec[i] = ((9'(i) + {1'b0, len}) >= 9'(ipc_pkg::FULL_PREFIX));
			end
		end else begin
			mask_vec[ipc_pkg::V4_W-1:0] = mask_val;
		end
	end

endmodule

// ----- hw/rtl/ip_prefix_compare_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_prefix_compare_top
// Compares a stated and a system IP address/mask pair under one operation.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while nothing stalls and answers each
// with one verdict transaction (true, false or error). Each transaction
// passes through the registered stages in order: one register stage
// normalizes the family and clamps IPv6 prefixes to 128, one compares the
// masks and applies the selected mask, one compares the 64-bit halves of
// the masked addresses, and the output register combines the verdict. A
// stall on the output backs up stage by stage; empty stages still accept,
// so up to four transactions are held in flight.
module ip_prefix_compare_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input transactions
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// operation[2:0], stated_addr_high[66:3], stated_addr_low[130:67],
	// stated_mask[162:131], system_addr_high[226:163], system_addr_low[290:227],
	// system_mask[322:291], zero pad above
	input  logic [ipc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// family[0]
	input  logic [0:0]                       s_axis_tuser,
	// Verdict transactions
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// verdict[1:0], zero pad above
	output logic [ipc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	// Input field slices
	logic                          in_v6;
	ipc_pkg::op_t                  in_op;
	logic [ipc_pkg::ADDR_W-1:0]    in_a1;
	logic [ipc_pkg::ADDR_W-1:0]    in_a2;
	logic [ipc_pkg::MASK_W-1:0]    in_m1;
	logic [ipc_pkg::MASK_W-1:0]    in_m2;

	// Stage 1: normalized operands
	logic                          valid_s1;
	logic                          v6_s1;
	ipc_pkg::op_t                  op_s1;
	logic [ipc_pkg::ADDR_W-1:0]    a1_s1;
	logic [ipc_pkg::ADDR_W-1:0]    a2_s1;
	logic [ipc_pkg::MASK_W-1:0]    m1_s1;
	logic [ipc_pkg::MASK_W-1:0]    m2_s1;

	// Stage 2: masked addresses and mask relation
	logic                          valid_s2;
	ipc_pkg::op_t                  op_s2;
	logic [ipc_pkg::ADDR_W-1:0]    x1_s2;
	logic [ipc_pkg::ADDR_W-1:0]    x2_s2;
	logic                          meq_s2;
	logic                          mlt_s2;
	logic                          raw_eq_s2;

	// Stage 3: half-word compare results
	logic                          valid_s3;
	ipc_pkg::op_t                  op_s3;
	logic                          meq_s3;
	logic                          mlt_s3;
	logic                          raw_eq_s3;
	logic                          hi_eq_s3;
	logic                          hi_lt_s3;
	logic                          lo_eq_s3;
	logic                          lo_lt_s3;

	// Output register
	logic                          out_valid_q;
	ipc_pkg::verdict_t             verdict_q;

	// Stage handshakes
	logic                          ready_s1;
	logic                          ready_s2;
	logic                          ready_s3;
	logic                          ready_out;

	// Stage 2 combinational values
	logic                          m_eq;
	logic                          m_lt;
	logic [ipc_pkg::MASK_W-1:0]    sel_mask;
	logic [ipc_pkg::ADDR_W-1:0]    mask_vec;

	// Verdict combine
	logic                          a_eq;
	logic                          a_lt;
	logic                          m_gt;
	ipc_pkg::verdict_t             verdict_d;

	// Unpack the input transaction
	assign in_v6 = s_axis_tuser[0];
	assign in_op = ipc_pkg::op_t'(s_axis_tdata[2:0]);
	assign in_m1 = s_axis_tdata[162:131];
	assign in_m2 = s_axis_tdata[322:291];

	// Drop the upper address bits for IPv4
	always_comb begin
		if (in_v6) begin
			in_a1 = {s_axis_tdata[66:3], s_axis_tdata[130:67]};
			in_a2 = {s_axis_tdata[226:163], s_axis_tdata[290:227]};
		end else begin
			in_a1 = {96'd0, s_axis_tdata[98:67]};
			in_a2 = {96'd0, s_axis_tdata[258:227]};
		end
	end

	// Advance a stage when it is empty or its successor advances
	assign ready_out     = !out_valid_q || m_axis_tready;
	assign ready_s3      = !valid_s3 || ready_out;
	assign ready_s2      = !valid_s2 || ready_s3;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	// Stage 1: capture operands, clamp IPv6 prefix lengths
	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			v6_s1 <= in_v6;
			op_s1 <= in_op;
			a1_s1 <= in_a1;
			a2_s1 <= in_a2;
			m1_s1 <= (in_v6 && (in_m1 > ipc_pkg::MASK_W'(ipc_pkg::FULL_PREFIX)))
				? ipc_pkg::MASK_W'(ipc_pkg::FULL_PREFIX) : in_m1;
			m2_s1 <= (in_v6 && (in_m2 > ipc_pkg::MASK_W'(ipc_pkg::FULL_PREFIX)))
				? ipc_pkg::MASK_W'(ipc_pkg::FULL_PREFIX) : in_m2;
		end
	end

	// Stage 2: relate the masks, pick the mask the operation applies
	assign m_eq     = (m1_s1 == m2_s1);
	assign m_lt     = (m1_s1 < m2_s1);
	assign sel_mask = (op_s1 == ipc_pkg::OP_SUPERSET) ? m2_s1 : m1_s1;

	ipc_prefix_mask u_mask (
		.v6       (v6_s1),
		.mask_val (sel_mask),
		.mask_vec (mask_vec)
	);

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			op_s2     <= op_s1;
			x1_s2     <= a1_s1 & mask_vec;
			x2_s2     <= a2_s1 & mask_vec;
			meq_s2    <= m_eq;
			mlt_s2    <= m_lt;
			raw_eq_s2 <= (a1_s1 == a2_s1);
		end
	end

	// Stage 3: compare the masked halves
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			op_s3     <= op_s2;
			meq_s3    <= meq_s2;
			mlt_s3    <= mlt_s2;
			raw_eq_s3 <= raw_eq_s2;
			hi_eq_s3  <= (x1_s2[ipc_pkg::ADDR_W-1:ipc_pkg::HALF_W]
				== x2_s2[ipc_pkg::ADDR_W-1:ipc_pkg::HALF_W]);
			hi_lt_s3  <= (x1_s2[ipc_pkg::ADDR_W-1:ipc_pkg::HALF_W]
				< x2_s2[ipc_pkg::ADDR_W-1:ipc_pkg::HALF_W]);
			lo_eq_s3  <= (x1_s2[ipc_pkg::HALF_W-1:0] == x2_s2[ipc_pkg::HALF_W-1:0]);
			lo_lt_s3  <= (x1_s2[ipc_pkg::HALF_W-1:0] < x2_s2[ipc_pkg::HALF_W-1:0]);
		end
	end

	// Combine the half-word results into the verdict
	assign a_eq = hi_eq_s3 && lo_eq_s3;
	assign a_lt = hi_eq_s3 ? lo_lt_s3 : hi_lt_s3;
	assign m_gt = !meq_s3 && !mlt_s3;

	always_comb begin
		verdict_d = ipc_pkg::V_FALSE;
		unique case (op_s3)
			ipc_pkg::OP_EQ: begin
				verdict_d = (raw_eq_s3 && meq_s3) ? ipc_pkg::V_TRUE : ipc_pkg::V_FALSE;
			end
			ipc_pkg::OP_NE: begin
				verdict_d = (raw_eq_s3 && meq_s3) ? ipc_pkg::V_FALSE : ipc_pkg::V_TRUE;
			end
			ipc_pkg::OP_SUBSET: begin
				verdict_d = (!m_gt && a_eq) ? ipc_pkg::V_TRUE : ipc_pkg::V_FALSE;
			end
			ipc_pkg::OP_SUPERSET: begin
				verdict_d = (!mlt_s3 && a_eq) ? ipc_pkg::V_TRUE : ipc_pkg::V_FALSE;
			end
			ipc_pkg::OP_GT: begin
				verdict_d = !meq_s3 ? ipc_pkg::V_ERROR
					: (a_lt ? ipc_pkg::V_TRUE : ipc_pkg::V_FALSE);
			end
			ipc_pkg::OP_GE: begin
				verdict_d = !meq_s3 ? ipc_pkg::V_ERROR
					: ((a_lt || a_eq) ? ipc_pkg::V_TRUE : ipc_pkg::V_FALSE);
			end
			ipc_pkg::OP_LT: begin
				verdict_d = !meq_s3 ? ipc_pkg::V_ERROR
					: ((!a_lt && !a_eq) ? ipc_pkg::V_TRUE : ipc_pkg::V_FALSE);
			end
			ipc_pkg::OP_LE: begin
				verdict_d = !meq_s3 ? ipc_pkg::V_ERROR
					: (!a_lt ? ipc_pkg::V_TRUE : ipc_pkg::V_FALSE);
			end
			default: begin
				verdict_d = ipc_pkg::V_ERROR;
			end
		endcase
	end

	// Output register: hold while the consumer stalls
	always_ff @(posedge clk) begin
		if (ready_out && valid_s3) begin
			verdict_q <= verdict_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, verdict_q};

endmodule

// ----- hw/rtl/ipc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks on the prefix compare block, bound to the top level.
// ----------------------------------------------------------------------------
`include "ip_prefix_compare_top_assert.svh"

module ipc_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [ipc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	// Stalled verdict holds until taken
	`IPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// Only the three verdict codes appear, pad bits stay zero
	`IPC_ASSERT_NOW(a_out_code, m_axis_tvalid, (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[7:2] == 6'd0))

	// Input backs off only when the whole pipeline is full behind a stalled output
	`IPC_ASSERT_NOW(a_in_backpressure, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

	// A closed input means a stalled verdict, still held in the next cycle
	`IPC_ASSERT_NEXT(a_in_full_hold, !s_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind ip_prefix_compare_top ipc_checker u_ipc_checker (.*);
